[rtl/swmf_pkg.sv]
// ----------------------------------------------------------------------------
// swmf_pkg
// Shared constants and types for the square-window median filter.
// ----------------------------------------------------------------------------
package swmf_pkg;

  localparam int MaxRadius  = 4;
  localparam int MaxWidth   = 1024;
  localparam int SampleBits = 16;

  localparam int WinSide  = 2 * MaxRadius + 1;
  localparam int WinMax   = WinSide * WinSide;
  localparam int LineDepth = WinSide * MaxWidth + WinSide;
  localparam int AddrW    = $clog2(LineDepth);
  localparam int PosW     = 23;
  localparam int XW       = $clog2(MaxWidth);
  localparam int YW       = 13;
  localparam int RW       = 3;
  localparam int WW       = 11;
  localparam int KW       = $clog2(WinSide);
  localparam int MidW     = $clog2(WinMax);

  localparam logic [1:0] CFG_RADIUS = 2'd0;
  localparam logic [1:0] CFG_WIDTH  = 2'd1;
  localparam logic [1:0] CFG_HEIGHT = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic [AddrW-1:0] pos_mod;
    logic [XW-1:0]    ox;
    logic [YW-1:0]    oy;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [RW-1:0]   radius;
    logic [WW-1:0]   width;
    logic [YW-1:0]   height;
    logic [PosW-1:0] total;
    logic [PosW-1:0] lag;
  } geom_t;

endpackage

[rtl/square_window_median_filter_top.sv]
// A pixel's result follows the request that completes its window; the first
// R*width+R sample requests give no result.
// The single read port of the line store feeds the sort chain one sample a
// cycle, and the back end works on one window at a time.
// Reset: synchronous, active low; positions clear and registers take radius 1,
// width 1024, height 1024. Requests wait after a write until hold_r runs out.
// ----------------------------------------------------------------------------
// square_window_median_filter_top
// Raster-order 2-D median filter over a clamped square window.
// ----------------------------------------------------------------------------
module square_window_median_filter_top
  import swmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [12:0]           cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SampleBits-1:0] in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SampleBits-1:0] out_median_value,
  output logic                  out_last_of_frame
);

  logic [RW-1:0] radius_r;
  logic [WW-1:0] width_r;
  logic [YW-1:0] height_r;
  geom_t         geom_r, geom_nxt;
  logic [1:0]    hold_r, hold_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 3'd1;
      width_r  <= 11'd1024;
      height_r <= 13'd1024;
      hold_r   <= 2'd2;
    end else begin
      hold_r <= hold_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS: radius_r <= cfg_wdata[RW-1:0];
          CFG_WIDTH:  width_r  <= cfg_wdata[WW-1:0];
          CFG_HEIGHT: height_r <= cfg_wdata[YW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    hold_nxt = cfg_we ? 2'd2 : ((hold_r != 2'd0) ? hold_r - 2'd1 : 2'd0);
    geom_nxt.radius = (radius_r > RW'(MaxRadius)) ? RW'(MaxRadius) : radius_r;
    if (width_r == '0) begin
      geom_nxt.width = 11'd1;
    end else if (width_r > WW'(MaxWidth)) begin
      geom_nxt.width = WW'(MaxWidth);
    end else begin
      geom_nxt.width = width_r;
    end
    geom_nxt.height = (height_r == '0) ? 13'd1 : height_r;
    geom_nxt.total  = PosW'({12'b0, geom_nxt.width} * {10'b0, geom_nxt.height});
    geom_nxt.lag    = PosW'({{(PosW-RW){1'b0}}, geom_nxt.radius} *
                            {{(PosW-WW){1'b0}}, geom_nxt.width})
                      + {{(PosW-RW){1'b0}}, geom_nxt.radius};
  end

  always_ff @(posedge clk) begin
    geom_r <= geom_nxt;
  end

  logic                  st_we;
  logic [AddrW-1:0]      st_waddr, st_raddr;
  logic [SampleBits-1:0] st_wdata, st_rdata;
  logic                  q_push, q_pop, q_empty, q_full, last_done;
  job_t                  q_job, q_head;

  swmf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom_r),
    .hold      (hold_r != 2'd0),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .in_sample (in_sample),
    .st_we     (st_we),
    .st_waddr  (st_waddr),
    .st_wdata  (st_wdata),
    .q_push    (q_push),
    .q_job     (q_job),
    .q_full    (q_full),
    .last_done (last_done)
  );

  swmf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head_job (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  swmf_ram #(
    .Width (SampleBits),
    .Depth (LineDepth)
  ) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  swmf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .geom              (geom_r),
    .q_empty           (q_empty),
    .q_head            (q_head),
    .q_pop             (q_pop),
    .st_raddr          (st_raddr),
    .st_rdata          (st_rdata),
    .last_done         (last_done),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_median_value  (out_median_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

[rtl/swmf_ram.sv]
// ----------------------------------------------------------------------------
// swmf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module swmf_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/swmf_queue.sv]
// ----------------------------------------------------------------------------
// swmf_queue
// Four-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module swmf_queue
  import swmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  localparam int QDepth = 4;

  job_t       q_r [QDepth];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign empty    = (cnt_r == 3'd0);
  assign full     = (cnt_r == 3'd4);
  assign head_job = q_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + {1'b0, push};
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= push_job;
    end
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue push while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue pop while empty");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("queue count out of range");
`endif

endmodule

[rtl/swmf_front.sv]
// ----------------------------------------------------------------------------
// swmf_front
// Accepts requests, writes samples to the line store, tracks raster
// positions and queues one job for every pixel that is ready to be filtered.
// ----------------------------------------------------------------------------
module swmf_front
  import swmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  geom_t                 geom,
  input  logic                  hold,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SampleBits-1:0] in_sample,
  output logic                  st_we,
  output logic [AddrW-1:0]      st_waddr,
  output logic [SampleBits-1:0] st_wdata,
  output logic                  q_push,
  output job_t                  q_job,
  input  logic                  q_full,
  input  logic                  last_done
);

  logic [PosW-1:0]  in_pos_r, in_pos_nxt;
  logic [PosW-1:0]  out_pos_r, out_pos_nxt;
  logic [AddrW-1:0] wa_r, wa_nxt;
  logic [AddrW-1:0] ra_r, ra_nxt;
  logic [XW-1:0]    ox_r, ox_nxt;
  logic [YW-1:0]    oy_r, oy_nxt;
  logic             last_pend_r, last_pend_nxt;

  logic [PosW-1:0]  ip0, op0;
  logic [AddrW-1:0] wa0, ra0;
  logic [XW-1:0]    ox0;
  logic [YW-1:0]    oy0;
  logic             restart, is_smp, emit, is_last, accept;

  assign in_ready = !hold && !q_full && !last_pend_r;
  assign accept   = in_valid && in_ready;

  always_comb begin
    restart = (in_pos_r > geom.total) || (out_pos_r >= geom.total) ||
              (out_pos_r > in_pos_r);
    ip0 = restart ? '0 : in_pos_r;
    op0 = restart ? '0 : out_pos_r;
    wa0 = restart ? '0 : wa_r;
    ra0 = restart ? '0 : ra_r;
    ox0 = restart ? '0 : ox_r;
    oy0 = restart ? '0 : oy_r;

    is_smp = (in_opcode == OP_SAMPLE) && (ip0 < geom.total);
    if (is_smp) begin
      emit = ({1'b0, ip0} + 24'd1) > ({1'b0, op0} + {1'b0, geom.lag});
    end else begin
      emit = (ip0 >= geom.total);
    end
    is_last = ({1'b0, op0} + 24'd1) >= {1'b0, geom.total};

    st_we    = accept && is_smp;
    st_waddr = wa0;
    st_wdata = in_sample;

    q_push       = accept && emit;
    q_job.pos_mod = ra0;
    q_job.ox      = ox0;
    q_job.oy      = oy0;
    q_job.last    = is_last;

    in_pos_nxt  = in_pos_r;
    out_pos_nxt = out_pos_r;
    wa_nxt      = wa_r;
    ra_nxt      = ra_r;
    ox_nxt      = ox_r;
    oy_nxt      = oy_r;
    if (accept) begin
      in_pos_nxt  = ip0 + {{(PosW-1){1'b0}}, is_smp};
      wa_nxt      = wa0;
      if (is_smp) begin
        wa_nxt = (wa0 == AddrW'(LineDepth - 1)) ? '0 : wa0 + 1'b1;
      end
      out_pos_nxt = op0;
      ra_nxt      = ra0;
      ox_nxt      = ox0;
      oy_nxt      = oy0;
      if (emit) begin
        if (is_last) begin
          in_pos_nxt  = '0;
          out_pos_nxt = '0;
          wa_nxt      = '0;
          ra_nxt      = '0;
          ox_nxt      = '0;
          oy_nxt      = '0;
        end else begin
          out_pos_nxt = op0 + 1'b1;
          ra_nxt      = (ra0 == AddrW'(LineDepth - 1)) ? '0 : ra0 + 1'b1;
          if ({1'b0, ox0} + 11'd1 == geom.width) begin
            ox_nxt = '0;
            oy_nxt = oy0 + 1'b1;
          end else begin
            ox_nxt = ox0 + 1'b1;
          end
        end
      end
    end

    // A new frame must not overwrite the store until the final window is read.
    last_pend_nxt = last_pend_r;
    if (q_push && is_last) begin
      last_pend_nxt = 1'b1;
    end else if (last_done) begin
      last_pend_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_pos_r    <= '0;
      out_pos_r   <= '0;
      wa_r        <= '0;
      ra_r        <= '0;
      ox_r        <= '0;
      oy_r        <= '0;
      last_pend_r <= 1'b0;
    end else begin
      in_pos_r    <= in_pos_nxt;
      out_pos_r   <= out_pos_nxt;
      wa_r        <= wa_nxt;
      ra_r        <= ra_nxt;
      ox_r        <= ox_nxt;
      oy_r        <= oy_nxt;
      last_pend_r <= last_pend_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_pend: assert property (@(posedge clk) disable iff (!rst_n)
    last_pend_r |-> !accept) else $error("request taken with last pixel pending");
  a_wa_range: assert property (@(posedge clk) disable iff (!rst_n)
    wa_r < AddrW'(LineDepth)) else $error("write address out of range");
  a_ra_range: assert property (@(posedge clk) disable iff (!rst_n)
    ra_r < AddrW'(LineDepth)) else $error("read base out of range");
`endif

endmodule

[rtl/swmf_back.sv]
// ----------------------------------------------------------------------------
// swmf_back
// Reads the clamped window from the line store, one sample per cycle, into
// an insertion-sort chain and delivers the middle element.
// ----------------------------------------------------------------------------
module swmf_back
  import swmf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  geom_t                 geom,
  input  logic                  q_empty,
  input  job_t                  q_head,
  output logic                  q_pop,
  output logic [AddrW-1:0]      st_raddr,
  input  logic [SampleBits-1:0] st_rdata,
  output logic                  last_done,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SampleBits-1:0] out_median_value,
  output logic                  out_last_of_frame
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  job_t        job_r, job_nxt;
  logic [KW-1:0] ky_r, ky_nxt, kx_r, kx_nxt;
  logic        rd_pend_r, rd_pend_nxt;
  logic        clr;

  logic [SampleBits-1:0] arr_r [WinMax];
  logic [SampleBits-1:0] arr_nxt [WinMax];
  logic [WinMax-1:0]     arr_v_r, arr_v_nxt;
  logic [WinMax-1:0]     gt;

  logic                  ov_r, ov_nxt;
  logic [SampleBits-1:0] om_r, om_nxt;
  logic                  ol_r, ol_nxt;
  logic                  load;

  logic [KW-1:0] side_m1;
  logic [MidW-1:0] mid;
  logic signed [YW+1:0] sy, yy, dy;
  logic signed [XW+1:0] sx, xx, dx;
  logic signed [16:0]   dyw, a;

  // Window address: offset from the centre added to its store address.
  always_comb begin
    side_m1 = {geom.radius, 1'b0};
    sy = $signed({2'b0, job_r.oy}) + $signed({{(YW+2-KW){1'b0}}, ky_r})
         - $signed({{(YW-1){1'b0}}, geom.radius});
    if (sy < 0) begin
      yy = '0;
    end else if (sy >= $signed({2'b0, geom.height})) begin
      yy = $signed({2'b0, geom.height}) - 1;
    end else begin
      yy = sy;
    end
    sx = $signed({2'b0, job_r.ox}) + $signed({{(XW+2-KW){1'b0}}, kx_r})
         - $signed({{(XW-1){1'b0}}, geom.radius});
    if (sx < 0) begin
      xx = '0;
    end else if (sx >= $signed({1'b0, geom.width})) begin
      xx = $signed({1'b0, geom.width}) - 1;
    end else begin
      xx = sx;
    end
    dy  = yy - $signed({2'b0, job_r.oy});
    dx  = xx - $signed({2'b0, job_r.ox});
    dyw = 17'($signed(dy[4:0]) * $signed({1'b0, geom.width}));
    a   = $signed({3'b0, job_r.pos_mod}) + dyw + 17'(dx);
    if (a < 0) begin
      a = a + 17'(LineDepth);
    end else if (a >= 17'(LineDepth)) begin
      a = a - 17'(LineDepth);
    end
    st_raddr = a[AddrW-1:0];
  end

  always_comb begin
    state_nxt   = state_r;
    job_nxt     = job_r;
    ky_nxt      = ky_r;
    kx_nxt      = kx_r;
    rd_pend_nxt = 1'b0;
    q_pop       = 1'b0;
    clr         = 1'b0;
    load        = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          clr       = 1'b1;
          job_nxt   = q_head;
          ky_nxt    = '0;
          kx_nxt    = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        rd_pend_nxt = 1'b1;
        if (kx_r == side_m1) begin
          kx_nxt = '0;
          ky_nxt = ky_r + 1'b1;
          if (ky_r == side_m1) begin
            state_nxt = ST_WAIT;
          end
        end else begin
          kx_nxt = kx_r + 1'b1;
        end
      end
      ST_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_r || out_ready) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Sorted chain, ascending; empty cells act as larger than any key.
  always_comb begin
    for (int i = 0; i < WinMax; i++) begin
      gt[i] = !arr_v_r[i] || ($signed(arr_r[i]) > $signed(st_rdata));
    end
    for (int i = 0; i < WinMax; i++) begin
      arr_nxt[i]   = arr_r[i];
      arr_v_nxt[i] = arr_v_r[i];
      if (clr) begin
        arr_v_nxt[i] = 1'b0;
      end else if (rd_pend_r && gt[i]) begin
        if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
          arr_nxt[i]   = arr_r[(i > 0) ? i - 1 : 0];
          arr_v_nxt[i] = arr_v_r[(i > 0) ? i - 1 : 0];
        end else begin
          arr_nxt[i]   = st_rdata;
          arr_v_nxt[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    mid    = MidW'(({3'b0, geom.radius} * {3'b0, geom.radius} + {3'b0, geom.radius}) << 1);
    ov_nxt = ov_r && !out_ready;
    om_nxt = om_r;
    ol_nxt = ol_r;
    if (load) begin
      ov_nxt = 1'b1;
      om_nxt = arr_r[mid];
      ol_nxt = job_r.last;
    end
  end

  assign last_done         = load && job_r.last;
  assign out_valid         = ov_r;
  assign out_median_value  = om_r;
  assign out_last_of_frame = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_pend_r <= 1'b0;
      ov_r      <= 1'b0;
      arr_v_r   <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_pend_r <= rd_pend_nxt;
      ov_r      <= ov_nxt;
      arr_v_r   <= arr_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ky_r  <= ky_nxt;
    kx_r  <= kx_nxt;
    om_r  <= om_nxt;
    ol_r  <= ol_nxt;
    for (int i = 0; i < WinMax; i++) begin
      arr_r[i] <= arr_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_pend_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    rd_pend_r |-> (state_r == ST_RUN || state_r == ST_WAIT))
    else $error("store data arrived outside a window read");
  a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> arr_v_r[mid]) else $error("median taken from an empty cell");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE) else $error("job popped while busy");
`endif

endmodule

[tb/sv/square_window_median_filter_top_tb.sv]
// ----------------------------------------------------------------------------
// square_window_median_filter_top_tb
// Self-checking bench for the square-window median filter. Frames of several
// sizes and radii are streamed in raster order and flushed with drain requests.
// A behavioral model predicts every median, and a scoreboard compares it with
// what the filter returns. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
class median_scoreboard;
  logic [15:0] exp_median[$];
  logic        exp_last[$];
  int          errors;
  int          checked;

  function void note_request(logic [15:0] med, logic last);
    exp_median.push_back(med);
    exp_last.push_back(last);
  endfunction

  function void check_result(logic [15:0] med, logic last);
    logic [15:0] em;
    logic        el;
    if (exp_median.size() == 0) begin
      $display("%0t: unexpected result median=%h last=%b", $time, med, last);
      errors++;
      return;
    end
    em = exp_median.pop_front();
    el = exp_last.pop_front();
    checked++;
    if (em !== med) begin
      $display("%0t: median mismatch expected %h actual %h", $time, em, med);
      errors++;
    end
    if (el !== last) begin
      $display("%0t: last flag mismatch expected %b actual %b", $time, el, last);
      errors++;
    end
  endfunction

  function int pending();
    return exp_median.size();
  endfunction
endclass

module square_window_median_filter_top_tb;
  import swmf_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_RADIUS;
  logic [12:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_opcode = OP_SAMPLE;
  logic [15:0] in_sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] out_median_value;
  logic out_last_of_frame;

  median_scoreboard sb;

  // Model copy of the registers and state.
  logic [2:0] m_radius;
  logic [10:0] m_width;
  logic [12:0] m_height;
  logic [15:0] pix_store[LineDepth];
  int unsigned in_pos;
  int unsigned out_pos;

  int unsigned items_sent;
  bit hold_receiver;

  square_window_median_filter_top dut (.*);

  always #10 clk = ~clk;

  function automatic int unsigned clampc(int v, int unsigned lim);
    if (v < 0) return 0;
    if (v >= int'(lim)) return lim - 1;
    return v;
  endfunction

  function automatic logic [15:0] window_median(int unsigned pos, int unsigned w,
                                                int unsigned h, int unsigned r);
    logic [15:0] keys[$];
    int oy;
    int ox;
    int unsigned yy;
    int unsigned xx;
    oy = pos / w;
    ox = pos % w;
    for (int dy = -int'(r); dy <= int'(r); dy++) begin
      yy = clampc(oy + dy, h);
      for (int dx = -int'(r); dx <= int'(r); dx++) begin
        xx = clampc(ox + dx, w);
        // Flipping the sign bit makes unsigned order match signed order.
        keys.push_back(pix_store[(yy * w + xx) % LineDepth] ^ 16'h8000);
      end
    end
    keys.sort();
    return keys[keys.size() / 2] ^ 16'h8000;
  endfunction

  // Advances the model by one accepted request and records any result.
  task automatic predict_request(logic op, logic [15:0] smp);
    int unsigned r;
    int unsigned w;
    int unsigned h;
    int unsigned total;
    int unsigned lag;
    bit emit;
    logic [15:0] med;
    r = (m_radius > MaxRadius) ? MaxRadius : m_radius;
    w = (m_width == 0) ? 1 : ((m_width > MaxWidth) ? MaxWidth : m_width);
    h = (m_height == 0) ? 1 : m_height;
    total = w * h;
    lag = r * w + r;
    emit = 0;
    if (in_pos > total || out_pos >= total || out_pos > in_pos) begin
      in_pos = 0;
      out_pos = 0;
    end
    if (op == OP_SAMPLE && in_pos < total) begin
      pix_store[in_pos % LineDepth] = smp;
      in_pos++;
      emit = in_pos > out_pos + lag;
    end else if (in_pos >= total) begin
      emit = 1;
    end
    if (emit) begin
      med = window_median(out_pos, w, h, r);
      out_pos++;
      if (out_pos >= total) begin
        sb.note_request(med, 1'b1);
        in_pos = 0;
        out_pos = 0;
      end else begin
        sb.note_request(med, 1'b0);
      end
    end
  endtask

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  // Valid stays high between back-to-back requests; it drops only for a gap.
  task automatic send_request(logic op, logic [15:0] smp);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_sample <= smp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(op, smp);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [12:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS: m_radius = val[2:0];
      CFG_WIDTH:  m_width = val[10:0];
      default:    m_height = val;
    endcase
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_sample(int mode);
    case (mode)
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom_range(0, 7));
      default: return 16'($urandom);
    endcase
  endfunction

  // A full frame of samples, an optional early drain or surplus, then drains.
  task automatic run_frame(int unsigned w, int unsigned h, int mode, bit noise);
    int unsigned total;
    total = w * h;
    for (int unsigned i = 0; i < total; i++) begin
      if (noise && $urandom_range(0, 9) == 0) send_request(OP_DRAIN, 16'($urandom));
      send_request(OP_SAMPLE, rand_sample(mode));
    end
    // A surplus sample only counts as one while the frame is still open.
    if (noise && in_pos != 0) send_request(OP_SAMPLE, 16'($urandom));
    while (sb.pending() != 0 || in_pos != 0) begin
      send_request(OP_DRAIN, 16'($urandom));
      if (in_pos == 0) break;
    end
  endtask

  task automatic set_geometry(int unsigned r, int unsigned w, int unsigned h);
    wait_idle();
    write_reg(CFG_RADIUS, 13'(r));
    write_reg(CFG_WIDTH, 13'(w));
    write_reg(CFG_HEIGHT, 13'(h));
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (1500) @(negedge clk);
        hold_receiver = 0;
      end
      hold = gap_len();
      if (hold != 0) begin
        out_ready <= 1'b0;
        repeat (hold - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_median_value, out_last_of_frame);
  end

  initial begin
    sb = new();
    m_radius = 1;
    m_width = 1024;
    m_height = 1024;
    in_pos = 0;
    out_pos = 0;
    items_sent = 0;
    hold_receiver = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    repeat (4) @(negedge clk);

    // Directed: extremes, radius zero, single pixel, oversize and zero settings.
    set_geometry(0, 1, 1);
    run_frame(1, 1, 0, 0);
    set_geometry(1, 3, 2);
    run_frame(3, 2, 1, 0);
    set_geometry(4, 2, 2);
    run_frame(2, 2, 2, 1);
    set_geometry(7, 0, 0);
    send_request(OP_DRAIN, 16'hffff);
    run_frame(1, 1, 3, 0);
    set_geometry(2, 1, 5);
    run_frame(1, 5, 0, 0);

    // Long receiver stall while requests keep coming.
    set_geometry(4, 6, 5);
    hold_receiver = 1;
    run_frame(6, 5, 3, 0);

    // Random frames; the sender pauses for a full drain between them.
    while (items_sent < 380) begin
      int unsigned r;
      int unsigned w;
      int unsigned h;
      r = $urandom_range(0, 4);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      if ($urandom_range(0, 7) == 0) w = $urandom_range(9, 20);
      set_geometry(r, w, h);
      run_frame(w, h, $urandom_range(2, 3), $urandom_range(0, 3) == 0);
    end

    // Width and height at their top register values, one short partial pass.
    wait_idle();
    write_reg(CFG_WIDTH, 13'd2047);
    write_reg(CFG_HEIGHT, 13'h1fff);
    write_reg(CFG_RADIUS, 13'd0);
    for (int i = 0; i < 8; i++) send_request(OP_SAMPLE, 16'($urandom));
    wait_idle();

    $display("Covered %0d requests over radii 0..7 and frames 1x1 up to 20x6,",
             items_sent);
    $display("with %0d medians checked, including drain, edge and oversize cases.",
             sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("square_window_median_filter_top_tb: done, clean");
    end else begin
      $display("square_window_median_filter_top_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("square_window_median_filter_top_tb: done, errors");
    $finish;
  end
endmodule
